// File: hdl/bhsc_pkg.sv
package bhsc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VEC_W     = 32;
    localparam int NRM_W     = 18;
    localparam int ACC_W     = 36;
    localparam int RAD_W     = 34;
    localparam int PEN_W     = 31;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 2;

    localparam logic [2:0] KIND_CENTRE = 3'd0;
    localparam logic [2:0] KIND_AXIS_X = 3'd1;
    localparam logic [2:0] KIND_AXIS_Y = 3'd2;
    localparam logic [2:0] KIND_AXIS_Z = 3'd3;
    localparam logic [2:0] KIND_HALF   = 3'd4;

    localparam logic [IDX_W-1:0] REG_NX     = 2'd0;
    localparam logic [IDX_W-1:0] REG_NY     = 2'd1;
    localparam logic [IDX_W-1:0] REG_NZ     = 2'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET = 2'd3;

    localparam logic signed [NRM_W-1:0] NRM_ONE = NRM_W'(1 << FRAC_BITS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RAD, ST_CDIST, ST_CHECK, ST_VERT,
        ST_VDIST, ST_VCHK, ST_PT, ST_EMIT, ST_CLOSE
    } state_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic signed [VEC_W-1:0] offset;
    } plane_t;

    typedef struct packed {
        logic                    contact_valid;
        logic [2:0]              vertex_index;
        logic signed [VEC_W-1:0] point_x;
        logic signed [VEC_W-1:0] point_y;
        logic signed [VEC_W-1:0] point_z;
        logic [PEN_W-1:0]        penetration;
        logic [CNT_W-1:0]        contact_count;
        logic                    last;
    } res_t;

    function automatic logic signed [VEC_W-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh000000007FFFFFFF)
            return 32'sh7FFFFFFF;
        else if (v < 64'shFFFFFFFF80000000)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [VEC_W-1:0] qneg(input logic signed [VEC_W-1:0] x);
        if (x == 32'sh80000000)
            return 32'sh7FFFFFFF;
        else
            return -x;
    endfunction

    function automatic logic signed [VEC_W-1:0] qabs(input logic signed [VEC_W-1:0] x);
        if (x < 0)
            return qneg(x);
        else
            return x;
    endfunction

endpackage

// File: hdl/bhsc_if.sv
interface bhsc_in_if;
    logic                             valid;
    logic                             ready;
    logic [2:0]                       kind;
    logic signed [bhsc_pkg::VEC_W-1:0] vec_x;
    logic signed [bhsc_pkg::VEC_W-1:0] vec_y;
    logic signed [bhsc_pkg::VEC_W-1:0] vec_z;

    modport source (output valid, kind, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, kind, vec_x, vec_y, vec_z, output ready);
endinterface

interface bhsc_out_if;
    logic                             valid;
    logic                             ready;
    logic                             contact_valid;
    logic [2:0]                       vertex_index;
    logic signed [bhsc_pkg::VEC_W-1:0] point_x;
    logic signed [bhsc_pkg::VEC_W-1:0] point_y;
    logic signed [bhsc_pkg::VEC_W-1:0] point_z;
    logic [bhsc_pkg::PEN_W-1:0]       penetration;
    logic [bhsc_pkg::CNT_W-1:0]       contact_count;
    logic                             last;

    modport source (output valid, contact_valid, vertex_index, point_x, point_y, point_z,
                    penetration, contact_count, last, input ready);
    modport sink   (input valid, contact_valid, vertex_index, point_x, point_y, point_z,
                    penetration, contact_count, last, output ready);
endinterface

// File: hdl/box_half_space_contact.sv
// A box test first forms the radius and checks the centre distance, then for each vertex
// forms the vertex and its plane distance, and for a contact the contact point, all on one
// shared registered multiplier; each contact, then a closing word, goes out as a result.
// Kinds 0 to 3 load the box store. One test at a time; the output register lets
// the next word in while the last result waits. Reset clears control state and the
// plane registers (normal 0,1,0, offset 0); the box store holds junk until loaded.
module box_half_space_contact (
    input  logic                              clk,
    input  logic                              rst_n,
    bhsc_in_if.sink                           box_in,
    bhsc_out_if.source                        contact_out,
    input  logic                              wr_en,
    input  logic [bhsc_pkg::IDX_W-1:0]        wr_index,
    input  logic [bhsc_pkg::VEC_W-1:0]        wr_data
);
    import bhsc_pkg::*;

    plane_t plane_reg;
    logic   res_valid, res_ready;
    res_t   res;
    logic   out_valid_reg;
    res_t   out_reg;

    bhsc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .box_in    (box_in),
        .plane     (plane_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.nx     <= '0;
            plane_reg.ny     <= NRM_ONE;
            plane_reg.nz     <= '0;
            plane_reg.offset <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_NX:     plane_reg.nx     <= wr_data[NRM_W-1:0];
                REG_NY:     plane_reg.ny     <= wr_data[NRM_W-1:0];
                REG_NZ:     plane_reg.nz     <= wr_data[NRM_W-1:0];
                REG_OFFSET: plane_reg.offset <= wr_data;
                default:    plane_reg.offset <= plane_reg.offset;
            endcase
        end
    end

    assign res_ready = !out_valid_reg || contact_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_reg <= res;
    end

    assign contact_out.valid         = out_valid_reg;
    assign contact_out.contact_valid = out_reg.contact_valid;
    assign contact_out.vertex_index  = out_reg.vertex_index;
    assign contact_out.point_x       = out_reg.point_x;
    assign contact_out.point_y       = out_reg.point_y;
    assign contact_out.point_z       = out_reg.point_z;
    assign contact_out.penetration   = out_reg.penetration;
    assign contact_out.contact_count = out_reg.contact_count;
    assign contact_out.last          = out_reg.last;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        contact_out.valid && !contact_out.ready |=> contact_out.valid && $stable(out_reg))
        else $error("output word dropped while stalled");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> contact_out.valid)
        else $error("result word lost");
    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        contact_out.valid && contact_out.contact_valid |-> !contact_out.last)
        else $error("contact word marked last");
`endif
endmodule

// File: hdl/bhsc_qmul.sv
module bhsc_qmul (
    input  logic                              clk,
    input  logic signed [bhsc_pkg::VEC_W-1:0] a,
    input  logic signed [bhsc_pkg::VEC_W-1:0] b,
    output logic signed [bhsc_pkg::VEC_W-1:0] q
);
    import bhsc_pkg::*;

    localparam logic signed [63:0] ROUND_MASK = 64'((64'sd1 <<< FRAC_BITS) - 1);

    logic signed [63:0]      prod;
    logic signed [63:0]      adj;
    logic signed [VEC_W-1:0] q_next;
    logic signed [VEC_W-1:0] q_reg;

    // truncate toward zero: bias negative products before the shift
    assign prod   = 64'(a) * 64'(b);
    assign adj    = prod + (prod[63] ? ROUND_MASK : 64'sd0);
    assign q_next = sat32(adj >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;
endmodule

// File: hdl/bhsc_core.sv
module bhsc_core (
    input  logic             clk,
    input  logic             rst_n,
    bhsc_in_if.sink          box_in,
    input  bhsc_pkg::plane_t plane,
    output logic             res_valid,
    input  logic             res_ready,
    output bhsc_pkg::res_t   res
);
    import bhsc_pkg::*;

    state_t state_reg, state_next;
    logic [1:0]       k_reg;
    logic [1:0]       c_reg;
    logic             ph_reg;
    logic [2:0]       v_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic signed [VEC_W-1:0] centre_reg [3];
    logic signed [VEC_W-1:0] axis_reg   [3][3];
    logic signed [VEC_W-1:0] half_reg   [3];
    logic signed [VEC_W-1:0] vert_reg   [3];
    logic signed [VEC_W-1:0] pt_reg     [3];
    logic signed [VEC_W-1:0] dist_reg;
    logic signed [VEC_W-1:0] diff_reg;
    logic [PEN_W-1:0]        pen_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [RAD_W-1:0] rad_reg;

    logic signed [VEC_W-1:0] nrm [3];
    logic signed [VEC_W-1:0] op_a, op_b, q;
    logic signed [ACC_W-1:0] sum;
    logic signed [VEC_W-1:0] acc_sat;
    logic signed [VEC_W-1:0] rad_sat;
    logic signed [32:0]      pdiff;
    logic                    in_acc, pass, hit;

    bhsc_qmul u_qmul (
        .clk (clk),
        .a   (op_a),
        .b   (op_b),
        .q   (q)
    );

    assign nrm[0]  = VEC_W'(plane.nx);
    assign nrm[1]  = VEC_W'(plane.ny);
    assign nrm[2]  = VEC_W'(plane.nz);
    assign in_acc  = box_in.valid && box_in.ready;
    assign box_in.ready = (state_reg == ST_IDLE);
    assign sum     = acc_reg + ACC_W'(q);
    assign acc_sat = sat32(64'(acc_reg));
    assign rad_sat = sat32(64'(rad_reg));
    assign pass    = (ACC_W'(acc_sat) - ACC_W'(rad_sat)) <= ACC_W'(plane.offset);
    assign hit     = dist_reg <= plane.offset;
    assign pdiff   = 33'(plane.offset) - 33'(dist_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc && box_in.kind == KIND_HALF)
                    state_next = ST_RAD;
            ST_RAD:
                if (ph_reg && k_reg == 2'd3 && c_reg == 2'd2)
                    state_next = ST_CDIST;
            ST_CDIST:
                if (ph_reg && k_reg == 2'd2)
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = pass ? ST_VERT : ST_CLOSE;
            ST_VERT:
                if (ph_reg && k_reg == 2'd2 && c_reg == 2'd2)
                    state_next = ST_VDIST;
            ST_VDIST:
                if (ph_reg && k_reg == 2'd2)
                    state_next = ST_VCHK;
            ST_VCHK:
                if (hit)
                    state_next = ST_PT;
                else
                    state_next = (v_reg == 3'd7) ? ST_CLOSE : ST_VERT;
            ST_PT:
                if (ph_reg && c_reg == 2'd2)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (res_ready)
                    state_next = (v_reg == 3'd7) ? ST_CLOSE : ST_VERT;
            ST_CLOSE:
                if (res_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_a      = '0;
        op_b      = '0;
        res_valid = 1'b0;
        res       = '0;
        unique case (state_reg)
            ST_RAD:
                if (k_reg == 2'd3)
                begin
                    op_a = half_reg[c_reg];
                    op_b = qabs(acc_sat);
                end
                else
                begin
                    op_a = nrm[k_reg];
                    op_b = axis_reg[c_reg][k_reg];
                end
            ST_CDIST:
            begin
                op_a = nrm[k_reg];
                op_b = centre_reg[k_reg];
            end
            ST_VERT:
            begin
                op_a = v_reg[k_reg] ? qneg(half_reg[k_reg]) : half_reg[k_reg];
                op_b = axis_reg[k_reg][c_reg];
            end
            ST_VDIST:
            begin
                op_a = nrm[k_reg];
                op_b = vert_reg[k_reg];
            end
            ST_PT:
            begin
                op_a = nrm[c_reg];
                op_b = diff_reg;
            end
            ST_EMIT:
            begin
                res_valid         = 1'b1;
                res.contact_valid = 1'b1;
                res.vertex_index  = v_reg;
                res.point_x       = pt_reg[0];
                res.point_y       = pt_reg[1];
                res.point_z       = pt_reg[2];
                res.penetration   = pen_reg;
            end
            ST_CLOSE:
            begin
                res_valid         = 1'b1;
                res.contact_count = cnt_reg;
                res.last          = 1'b1;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            c_reg     <= '0;
            ph_reg    <= 1'b0;
            v_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                    if (in_acc && box_in.kind == KIND_HALF)
                    begin
                        k_reg   <= '0;
                        c_reg   <= '0;
                        v_reg   <= '0;
                        cnt_reg <= '0;
                    end
                ST_RAD:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        k_reg <= k_reg + 2'd1;
                        if (k_reg == 2'd3)
                            c_reg <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
                    end
                end
                ST_CDIST, ST_VDIST:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                        k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                end
                ST_VERT:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                        if (k_reg == 2'd2)
                            c_reg <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
                    end
                end
                ST_VCHK:
                    if (!hit)
                        v_reg <= v_reg + 3'd1;
                ST_PT:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                        c_reg <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
                end
                ST_EMIT:
                    if (res_ready)
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                        v_reg   <= v_reg + 3'd1;
                    end
                default:
                    ph_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    unique case (box_in.kind)
                        KIND_CENTRE:
                        begin
                            centre_reg[0] <= box_in.vec_x;
                            centre_reg[1] <= box_in.vec_y;
                            centre_reg[2] <= box_in.vec_z;
                        end
                        KIND_AXIS_X, KIND_AXIS_Y, KIND_AXIS_Z:
                        begin
                            axis_reg[2'(box_in.kind - KIND_AXIS_X)][0] <= box_in.vec_x;
                            axis_reg[2'(box_in.kind - KIND_AXIS_X)][1] <= box_in.vec_y;
                            axis_reg[2'(box_in.kind - KIND_AXIS_X)][2] <= box_in.vec_z;
                        end
                        KIND_HALF:
                        begin
                            half_reg[0] <= box_in.vec_x;
                            half_reg[1] <= box_in.vec_y;
                            half_reg[2] <= box_in.vec_z;
                            acc_reg     <= '0;
                            rad_reg     <= '0;
                        end
                        default:
                            acc_reg <= acc_reg;
                    endcase
                end
            ST_RAD:
                if (ph_reg)
                begin
                    if (k_reg == 2'd3)
                    begin
                        rad_reg <= rad_reg + RAD_W'(q);
                        acc_reg <= '0;
                    end
                    else
                        acc_reg <= sum;
                end
            ST_CDIST:
                if (ph_reg)
                    acc_reg <= sum;
            ST_CHECK:
                acc_reg <= ACC_W'(centre_reg[0]);
            ST_VERT:
                if (ph_reg)
                begin
                    if (k_reg == 2'd2)
                    begin
                        vert_reg[c_reg] <= sat32(64'(sum));
                        acc_reg <= (c_reg == 2'd2) ? '0 : ACC_W'(centre_reg[2'(c_reg + 2'd1)]);
                    end
                    else
                        acc_reg <= sum;
                end
            ST_VDIST:
                if (ph_reg)
                begin
                    acc_reg <= sum;
                    if (k_reg == 2'd2)
                        dist_reg <= sat32(64'(sum));
                end
            ST_VCHK:
                if (hit)
                begin
                    diff_reg <= sat32(64'(dist_reg) - 64'(plane.offset));
                    pen_reg  <= (pdiff > 33'sh07FFFFFFF) ? 31'h7FFFFFFF : pdiff[PEN_W-1:0];
                    acc_reg  <= ACC_W'(vert_reg[0]);
                end
                else
                    acc_reg <= ACC_W'(centre_reg[0]);
            ST_PT:
                if (ph_reg)
                begin
                    pt_reg[c_reg] <= sat32(64'(sum));
                    if (c_reg != 2'd2)
                        acc_reg <= ACC_W'(vert_reg[2'(c_reg + 2'd1)]);
                end
            ST_EMIT:
                acc_reg <= ACC_W'(centre_reg[0]);
            default:
                acc_reg <= acc_reg;
        endcase
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'd8)
        else $error("contact count above eight");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && box_in.kind == KIND_HALF |=> state_reg == ST_RAD && cnt_reg == 4'd0)
        else $error("test did not start");
    a_close_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |-> !res.contact_valid && res.contact_count == cnt_reg)
        else $error("bad closing word");
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_RAD |-> k_reg != 2'd3)
        else $error("term counter out of range");
`endif
endmodule

// File: tb/tb_box_half_space_contact.sv
module tb_box_half_space_contact;
    timeunit 1ns;
    timeprecision 1ps;
    import bhsc_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [IDX_W-1:0] wr_index = '0;
    logic [VEC_W-1:0] wr_data = '0;

    bhsc_in_if box_in();
    bhsc_out_if contact_out();

    box_half_space_contact uut (
        .clk(clk), .rst_n(rst_n), .box_in(box_in.sink), .contact_out(contact_out.source),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always #5 clk = ~clk;

    class contact_board;
        longint centre[3];
        longint axes[9];
        longint halfs[3];
        longint nrm[3];
        longint ofs;
        res_t pending[$];
        int mismatches;

        function new();
            nrm[0] = 0;
            nrm[1] = longint'(1) << FRAC_BITS;
            nrm[2] = 0;
            ofs = 0;
            mismatches = 0;
            foreach (centre[i]) centre[i] = 0;
            foreach (axes[i]) axes[i] = 0;
            foreach (halfs[i]) halfs[i] = 0;
        endfunction

        function longint clamp(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint fxmul(longint a, longint b);
            longint p;
            p = a * b;
            if (p < 0) return clamp(-((-p) >>> FRAC_BITS));
            return clamp(p >>> FRAC_BITS);
        endfunction

        function longint project(longint a0, longint a1, longint a2);
            return clamp(fxmul(nrm[0], a0) + fxmul(nrm[1], a1) + fxmul(nrm[2], a2));
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [VEC_W-1:0] d);
            if (idx == REG_OFFSET) ofs = longint'($signed(d));
            else nrm[idx] = longint'($signed(d[NRM_W-1:0]));
        endfunction

        function void push(bit cv, int idx, longint px, longint py, longint pz,
                           longint pen, int cnt, bit lst);
            res_t r;
            r.contact_valid = cv;
            r.vertex_index = idx[2:0];
            r.point_x = px[31:0];
            r.point_y = py[31:0];
            r.point_z = pz[31:0];
            r.penetration = pen[PEN_W-1:0];
            r.contact_count = cnt[CNT_W-1:0];
            r.last = lst;
            pending = {pending, r};
        endfunction

        function void note_word(logic [2:0] k, logic [VEC_W-1:0] x, logic [VEC_W-1:0] y,
                                logic [VEC_W-1:0] z);
            longint v[3];
            longint rad, h, acc, vdist, diff, pen, a;
            longint vert[3], pt[3];
            int n;
            v[0] = longint'($signed(x));
            v[1] = longint'($signed(y));
            v[2] = longint'($signed(z));
            if (k == KIND_CENTRE)
                foreach (v[c]) centre[c] = v[c];
            else if (k == KIND_AXIS_X || k == KIND_AXIS_Y || k == KIND_AXIS_Z)
                foreach (v[c]) axes[3 * (k - 1) + c] = v[c];
            else if (k == KIND_HALF) begin
                foreach (v[c]) halfs[c] = v[c];
                rad = 0;
                for (int i = 0; i < 3; i++)
                begin
                    a = project(axes[3*i], axes[3*i+1], axes[3*i+2]);
                    a = clamp(a < 0 ? -a : a);
                    rad += fxmul(halfs[i], a);
                end
                rad = clamp(rad);
                n = 0;
                if (project(centre[0], centre[1], centre[2]) - rad <= ofs) begin
                    for (int vi = 0; vi < 8; vi++)
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            acc = centre[c];
                            for (int i = 0; i < 3; i++)
                            begin
                                h = halfs[i];
                                if ((vi >> i) & 1) h = clamp(-h);
                                acc += fxmul(h, axes[3*i+c]);
                            end
                            vert[c] = clamp(acc);
                        end
                        vdist = project(vert[0], vert[1], vert[2]);
                        if (vdist <= ofs) begin
                            diff = clamp(vdist - ofs);
                            for (int c = 0; c < 3; c++)
                                pt[c] = clamp(vert[c] + fxmul(nrm[c], diff));
                            pen = ofs - vdist;
                            if (pen > 64'sd2147483647) pen = 64'sd2147483647;
                            push(1'b1, vi, pt[0], pt[1], pt[2], pen, 0, 1'b0);
                            n++;
                        end
                    end
                end
                push(1'b0, 0, 0, 0, 0, 0, n, 1'b1);
            end
        endfunction

        function void check_word(res_t got);
            res_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    contact_board board = new();
    bit quiet = 1'b0;
    bit hold_rx = 1'b0;
    int cycles = 0;
    int accepted = 0;

    initial
    begin
        box_in.valid = 1'b0;
        box_in.kind = '0;
        box_in.vec_x = '0;
        box_in.vec_y = '0;
        box_in.vec_z = '0;
        contact_out.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        res_t r;
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && box_in.valid && box_in.ready) begin
            board.note_word(box_in.kind, box_in.vec_x, box_in.vec_y, box_in.vec_z);
            accepted++;
        end
        if (rst_n && contact_out.valid && contact_out.ready) begin
            r.contact_valid = contact_out.contact_valid;
            r.vertex_index = contact_out.vertex_index;
            r.point_x = contact_out.point_x;
            r.point_y = contact_out.point_y;
            r.point_z = contact_out.point_z;
            r.penetration = contact_out.penetration;
            r.contact_count = contact_out.contact_count;
            r.last = contact_out.last;
            board.check_word(r);
        end
    end

    always @(negedge clk)
        contact_out.ready <= rst_n && !hold_rx && (quiet || $urandom_range(99) >= 6);

    task automatic send_word(logic [2:0] k, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int target;
        while (!quiet && $urandom_range(99) < 6)
        begin
            box_in.valid = 1'b0;
            @(negedge clk);
        end
        target = accepted + 1;
        box_in.valid = 1'b1;
        box_in.kind = k;
        box_in.vec_x = x;
        box_in.vec_y = y;
        box_in.vec_z = z;
        do @(negedge clk); while (accepted < target);
        box_in.valid = 1'b0;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] d);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = d;
        @(negedge clk);
        wr_en = 1'b0;
        board.set_reg(idx, d);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    function automatic logic [31:0] rnd_val(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
        endcase
    endfunction

    task automatic send_box(int mode);
        send_word(KIND_CENTRE, rnd_val(mode), rnd_val(mode), rnd_val(mode));
        send_word(KIND_AXIS_X, rnd_val(2), rnd_val(2), rnd_val(2));
        send_word(KIND_AXIS_Y, rnd_val(2), rnd_val(2), rnd_val(2));
        send_word(KIND_AXIS_Z, rnd_val(2), rnd_val(2), rnd_val(2));
        send_word(KIND_HALF, rnd_val(mode), rnd_val(mode), rnd_val(mode));
    endtask

    task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic [31:0] o);
        write_reg(REG_NX, nx);
        write_reg(REG_NY, ny);
        write_reg(REG_NZ, nz);
        write_reg(REG_OFFSET, o);
    endtask

    initial
    begin
        int k;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unit box at origin, default floor plane
        send_word(KIND_CENTRE, 0, 0, 0);
        send_word(KIND_AXIS_X, 32'h10000, 0, 0);
        send_word(KIND_AXIS_Y, 0, 32'h10000, 0);
        send_word(KIND_AXIS_Z, 0, 0, 32'h10000);
        send_word(KIND_HALF, 32'h10000, 32'h10000, 32'h10000);
        send_word(3'd5, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_word(3'd7, 0, 0, 0);
        send_word(KIND_CENTRE, 0, 32'h00100000, 0);
        send_word(KIND_HALF, 32'h10000, 32'h10000, 32'h10000);
        send_word(KIND_CENTRE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_word(KIND_AXIS_X, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        send_word(KIND_HALF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        drain();

        set_plane(32'h3FFFF, 32'h20000, 32'h00001, 32'h80000000);
        send_word(KIND_HALF, 32'h7FFFFFFF, 32'h80000000, 32'h00000001);
        drain();
        set_plane(32'h10000, 32'h30000, 32'h10000, 32'h7FFFFFFF);
        send_word(KIND_CENTRE, 32'h80000000, 32'h80000000, 32'h80000000);
        send_word(KIND_HALF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        drain();

        // receiver held off while boxes keep coming
        hold_rx = 1'b1;
        set_plane(0, 32'h10000, 0, 32'h20000);
        fork
            begin
                repeat (3) send_box(2);
            end
            begin
                repeat (1500) @(negedge clk);
                hold_rx = 1'b0;
            end
        join
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_plane(32'h10000, 0, 0, 0);
                1: set_plane(32'h0B505, 32'h3_4AFB, 32'h00000, 32'h8000);
                2: set_plane($urandom(), $urandom(), $urandom(), $urandom());
                default: set_plane(32'h3_0000, 32'h3_0000, 32'h3_0000, rnd_val(1));
            endcase
            quiet = (ph == 1);
            for (int b = 0; b < 6; b++)
            begin
                k = $urandom_range(9);
                if (k == 0) send_word(3'($urandom_range(5, 7)), $urandom(), $urandom(), 0);
                else if (k == 1) send_word(KIND_HALF, rnd_val(0), rnd_val(0), rnd_val(0));
                else send_box(k == 2 ? 0 : 1);
            end
            drain();
        end
        quiet = 1'b0;

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: box_half_space_contact.f
hdl/bhsc_pkg.sv
hdl/bhsc_if.sv
hdl/bhsc_qmul.sv
hdl/bhsc_core.sv
hdl/box_half_space_contact.sv
tb/tb_box_half_space_contact.sv
